@@ rtl/lmep_pkg.sv @@
// Types and constants shared by the list-mode event record parser.
package lmep_pkg;

   localparam logic KIND_EVENT  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam int MASK_RAW   = 0;
   localparam int MASK_CAL   = 1;
   localparam int MASK_SHORT = 2;
   localparam int MASK_WAVE  = 3;

   localparam int FLAG_PILEUP = 0;
   localparam int FLAG_SAT    = 1;

   localparam logic [5:0] POS_CHANNEL = 6'd2;
   localparam logic [5:0] POS_TIME    = 6'd4;
   localparam logic [5:0] POS_TS_LAST = 6'd11;
   localparam logic [5:0] POS_RAW     = 6'd12;
   localparam logic [5:0] LEN_RAW     = 6'd2;
   localparam logic [5:0] LEN_CAL     = 6'd8;
   localparam logic [5:0] LEN_SHORT   = 6'd2;
   localparam logic [5:0] LEN_FLAGS   = 6'd4;
   localparam logic [5:0] LEN_WAVE    = 6'd5;

   localparam logic [10:0] PS_PER_NS = 11'd1000;
   localparam logic [22:0] NS_RECIP  = 23'd4294967;

   typedef struct packed {
      logic        kind;
      logic [15:0] board;
      logic [15:0] channel;
      logic [63:0] timestamp_ps;
      logic [54:0] timestamp_ns;
      logic [15:0] value;
      logic [63:0] cal_pattern;
      logic [15:0] short_gate;
      logic [2:0]  status;
      logic [31:0] trace_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] time_ps;
   } div_req_type;

endpackage

@@ rtl/lmep_ns_div.sv @@
// Picosecond to nanosecond divider: three radix-2^21 long-division steps by 1000.
module lmep_ns_div
   import lmep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output logic        busy,
   output logic [54:0] ns
);

   localparam logic [1:0] STEP_HIGH = 2'd0;
   localparam logic [1:0] STEP_MID  = 2'd1;
   localparam logic [1:0] STEP_LOW  = 2'd2;

   logic        run_ff, run_in;
   logic [1:0]  step_ff, step_in;
   logic [54:0] quo_ff, quo_in;
   logic [9:0]  rem_ff, rem_in;

   logic [31:0] num;
   logic [54:0] prod;
   logic [22:0] q_est;
   logic [32:0] q_times;
   logic [32:0] r_est;
   logic [22:0] q_dig;
   logic [10:0] r_dig;

   always_comb begin
      unique case (step_ff)
         STEP_HIGH: num = {10'b0, div_req.time_ps[63:42]};
         STEP_MID:  num = {1'b0, rem_ff, div_req.time_ps[41:21]};
         default:   num = {1'b0, rem_ff, div_req.time_ps[20:0]};
      endcase
      prod    = 55'(num) * 55'(NS_RECIP);
      q_est   = prod[54:32];
      q_times = {q_est, 10'b0} - {6'b0, q_est, 4'b0} - {7'b0, q_est, 3'b0};
      r_est   = {1'b0, num} - q_times;
      if (r_est[10:0] >= PS_PER_NS) begin
         q_dig = q_est + 23'd1;
         r_dig = r_est[10:0] - PS_PER_NS;
      end else begin
         q_dig = q_est;
         r_dig = r_est[10:0];
      end
   end

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         run_in  = 1'b1;
         step_in = STEP_HIGH;
      end else if (run_ff) begin
         rem_in = r_dig[9:0];
         if (step_ff == STEP_HIGH) begin
            quo_in = 55'(q_dig);
         end else begin
            quo_in = {quo_ff[33:0], q_dig[20:0]};
         end
         if (step_ff == STEP_LOW) begin
            run_in = 1'b0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= STEP_HIGH;
         quo_ff  <= '0;
         rem_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy = run_ff;
   assign ns   = quo_ff;

endmodule

@@ rtl/lmep_parse.sv @@
// Record field assembly, trace sample pairing and result formation.
module lmep_parse
   import lmep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        restart,
   input  logic [3:0]  field_mask,
   input  logic [54:0] ns,
   output logic        res_valid,
   output rsp_type     res,
   output div_req_type div_req
);

   logic [5:0]  pos_ff, pos_in;
   logic        in_trace_ff, in_trace_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  low_ff, low_in;
   logic [63:0] prev_ff, prev_in;
   logic [15:0] board_ff, board_in;
   logic [15:0] channel_ff, channel_in;
   logic [63:0] time_ff, time_in;
   logic [15:0] raw_ff, raw_in;
   logic [63:0] cal_ff, cal_in;
   logic [15:0] short_ff, short_in;
   logic [1:0]  flag_ff, flag_in;
   logic [31:0] count_ff, count_in;

   logic        trace_now;
   logic [5:0]  p, p_next, o_cal, o_short, o_flags, o_wave, end_pos;
   logic [5:0]  off, off_cnt;
   logic [31:0] left_dec, tlen;
   logic        clr;

   always_comb begin
      pos_in      = pos_ff;
      in_trace_in = in_trace_ff;
      left_in     = left_ff;
      low_in      = low_ff;
      prev_in     = prev_ff;
      board_in    = board_ff;
      channel_in  = channel_ff;
      time_in     = time_ff;
      raw_in      = raw_ff;
      cal_in      = cal_ff;
      short_in    = short_ff;
      flag_in     = flag_ff;
      count_in    = count_ff;
      res_valid   = 1'b0;
      res         = '0;
      trace_now   = in_trace_ff & ~restart;
      p           = restart ? 6'd0 : pos_ff;
      p_next      = p + 6'd1;
      clr         = (p == 6'd0);
      o_cal       = POS_RAW + (field_mask[MASK_RAW] ? LEN_RAW : 6'd0);
      o_short     = o_cal + (field_mask[MASK_CAL] ? LEN_CAL : 6'd0);
      o_flags     = o_short + (field_mask[MASK_SHORT] ? LEN_SHORT : 6'd0);
      o_wave      = o_flags + LEN_FLAGS;
      end_pos     = o_wave + (field_mask[MASK_WAVE] ? LEN_WAVE : 6'd0);
      off         = '0;
      off_cnt     = '0;
      left_dec    = left_ff - 32'd1;
      tlen        = '0;
      div_req.start   = accept & ~trace_now & (p == POS_TS_LAST);
      div_req.time_ps = time_ff;
      if (accept) begin
         if (trace_now) begin
            if (!pos_ff[0]) begin
               low_in = data_byte;
               pos_in = 6'd1;
            end else begin
               left_in = left_dec;
               pos_in  = 6'd0;
               if (left_dec == '0) begin
                  in_trace_in = 1'b0;
               end
               res_valid        = 1'b1;
               res.kind         = KIND_SAMPLE;
               res.board        = board_ff;
               res.channel      = channel_ff;
               res.timestamp_ps = time_ff;
               res.timestamp_ns = ns;
               res.value        = {data_byte, low_ff};
               res.last         = (left_dec == '0);
            end
         end else begin
            in_trace_in = 1'b0;
            if (clr) begin
               board_in   = '0;
               channel_in = '0;
               time_in    = '0;
               raw_in     = '0;
               cal_in     = '0;
               short_in   = '0;
               flag_in    = '0;
               count_in   = '0;
            end
            priority if (p < POS_CHANNEL) begin
               board_in = board_in | ({8'b0, data_byte} << {p[0], 3'b0});
            end else if (p < POS_TIME) begin
               off        = p - POS_CHANNEL;
               channel_in = channel_in | ({8'b0, data_byte} << {off[0], 3'b0});
            end else if (p < POS_RAW) begin
               off     = p - POS_TIME;
               time_in = time_in | ({56'b0, data_byte} << {off[2:0], 3'b0});
            end else if (p < o_cal) begin
               off    = p - POS_RAW;
               raw_in = raw_in | ({8'b0, data_byte} << {off[0], 3'b0});
            end else if (p < o_short) begin
               off    = p - o_cal;
               cal_in = cal_in | ({56'b0, data_byte} << {off[2:0], 3'b0});
            end else if (p < o_flags) begin
               off      = p - o_short;
               short_in = short_in | ({8'b0, data_byte} << {off[0], 3'b0});
            end else if (p < o_wave) begin
               off = p - o_flags;
               if (off == 6'd0 && data_byte[7]) begin
                  flag_in[FLAG_SAT] = 1'b1;
               end
               if (off == 6'd1) begin
                  if (data_byte[7]) begin
                     flag_in[FLAG_PILEUP] = 1'b1;
                  end
                  if (data_byte[2]) begin
                     flag_in[FLAG_SAT] = 1'b1;
                  end
               end
            end else if (p < end_pos) begin
               off = p - o_wave;
               if (off != 6'd0) begin
                  off_cnt  = off - 6'd1;
                  count_in = count_in | ({24'b0, data_byte} << {off_cnt[1:0], 3'b0});
               end
            end else begin
               off = '0;
            end
            if (p_next < end_pos) begin
               pos_in = p_next;
            end else begin
               tlen    = field_mask[MASK_WAVE] ? count_in : 32'd0;
               prev_in = time_in;
               pos_in  = 6'd0;
               if (tlen != '0) begin
                  in_trace_in = 1'b1;
                  left_in     = tlen;
               end
               res_valid        = 1'b1;
               res.kind         = KIND_EVENT;
               res.board        = board_in;
               res.channel      = channel_in;
               res.timestamp_ps = time_in;
               res.timestamp_ns = ns;
               res.value        = raw_in;
               res.cal_pattern  = cal_in;
               res.short_gate   = short_in;
               res.status       = {time_in < prev_ff, flag_in};
               res.trace_length = tlen;
               res.last         = (tlen == '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         in_trace_ff <= 1'b0;
         left_ff     <= '0;
         low_ff      <= '0;
         prev_ff     <= '0;
         board_ff    <= '0;
         channel_ff  <= '0;
         time_ff     <= '0;
         raw_ff      <= '0;
         cal_ff      <= '0;
         short_ff    <= '0;
         flag_ff     <= '0;
         count_ff    <= '0;
      end else begin
         pos_ff      <= pos_in;
         in_trace_ff <= in_trace_in;
         left_ff     <= left_in;
         low_ff      <= low_in;
         prev_ff     <= prev_in;
         board_ff    <= board_in;
         channel_ff  <= channel_in;
         time_ff     <= time_in;
         raw_ff      <= raw_in;
         cal_ff      <= cal_in;
         short_ff    <= short_in;
         flag_ff     <= flag_in;
         count_ff    <= count_in;
      end
   end

endmodule

@@ rtl/list_mode_event_record_parser.sv @@
// Top level of the list-mode event record parser: field mask, parser, divider, result register.
// A result is registered and shows on rsp_tvalid in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; req_tready drops only while a held result is not taken.
// The ns divider runs its three steps after the last timestamp byte; four or more bytes follow.
// Reset (synchronous, active high) clears the record position, trace state, previous
// timestamp, field mask and result valid.
module list_mode_event_record_parser
   import lmep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte[7:0]
   input  logic         req_tuser,   // restart
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // board[15:0], channel[31:16], timestamp_ps[95:32], timestamp_ns[150:96],
   // value[166:151], cal_pattern[230:167], short_gate[246:231],
   // status[249:247], trace_length[281:250], zero[287:282]
   output logic [287:0] rsp_tdata,
   output logic         rsp_tuser,   // kind
   output logic         rsp_tlast,   // last
   input  logic         csr_wr_en,
   input  logic [3:0]   csr_wr_data  // field_mask
);

   logic [3:0]  mask_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        accept;
   logic        res_valid;
   rsp_type     res;
   div_req_type div_req;
   logic        div_busy;
   logic [54:0] ns;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   lmep_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .restart    (req_tuser),
      .field_mask (mask_ff),
      .ns         (ns),
      .res_valid  (res_valid),
      .res        (res),
      .div_req    (div_req)
   );

   lmep_ns_div u_ns_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .busy    (div_busy),
      .ns      (ns)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {6'b0, rsp_ff.trace_length, rsp_ff.status, rsp_ff.short_gate,
                        rsp_ff.cal_pattern, rsp_ff.value, rsp_ff.timestamp_ns,
                        rsp_ff.timestamp_ps, rsp_ff.channel, rsp_ff.board};

   a_div_done_at_event: assert property (@(posedge clock) disable iff (reset)
      accept && res_valid && res.kind == KIND_EVENT |-> !div_busy)
      else $error("event emitted before ns division finished");

   a_result_registered: assert property (@(posedge clock) disable iff (reset)
      accept && res_valid |=> rsp_valid_ff)
      else $error("result lost on its way to the output register");

   a_sample_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_SAMPLE |->
         rsp_ff.status == 3'd0 && rsp_ff.trace_length == '0 && rsp_ff.cal_pattern == '0)
      else $error("trace sample carries event-only fields");

   a_event_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_EVENT |-> rsp_ff.last == (rsp_ff.trace_length == '0))
      else $error("event last flag disagrees with trace length");

endmodule
